>>> rtl/tls_pkg.sv
// Shared types, constants and register codes of the triangle Lambert shading block.
`default_nettype none
package tls_pkg;
   localparam int COORD_BITS_DEF = 24;
   localparam int NORM_BITS = 30;
   localparam int NN_W = 62;
   localparam int ROOT_W = 31;
   localparam int SQ_REM_W = 64;
   localparam int DOT_W = 48;
   localparam int DIV_W = 48;
   localparam int QUOT_BITS = 16;
   localparam int Q16_W = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 17;
   localparam logic [Q16_W-1:0] Q16_ONE = 17'd65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_FLOOR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_FRACTION = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_WEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_EAST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_NORTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_UP = 3'd5;

   localparam logic [15:0] LIGHT_EAST_RST = 16'd14746;
   localparam logic [15:0] LIGHT_NORTH_RST = 16'd8192;
   localparam logic [15:0] LIGHT_UP_RST = 16'd28180;

   typedef struct packed {
      logic [Q16_W-1:0] night_floor;
      logic [Q16_W-1:0] day_fraction;
      logic [15:0] direct_weight;
      logic signed [15:0] light_east;
      logic signed [15:0] light_north;
      logic signed [15:0] light_up;
   } cfg_type;

   typedef struct packed {
      logic [NN_W-1:0] nn;
      logic signed [DOT_W-1:0] dot;
      logic degen;
   } norm_type;

   typedef struct packed {
      logic [ROOT_W-1:0] len;
      logic signed [DOT_W-1:0] dot;
      logic degen;
   } root_type;

   typedef struct packed {
      logic [Q16_W-1:0] incidence;
      logic degen;
   } inc_type;
endpackage
`default_nettype wire

>>> rtl/tls_normal.sv
// Face normal, scaling to 30 bits, squared length and light dot product (7 stages).
`default_nettype none
module tls_normal #(
   parameter int COORD_BITS = tls_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire tls_pkg::cfg_type cfg,
   input  wire logic in_valid,
   input  wire logic signed [COORD_BITS-1:0] a_east,
   input  wire logic signed [COORD_BITS-1:0] a_north,
   input  wire logic signed [COORD_BITS-1:0] a_up,
   input  wire logic signed [COORD_BITS-1:0] b_east,
   input  wire logic signed [COORD_BITS-1:0] b_north,
   input  wire logic signed [COORD_BITS-1:0] b_up,
   input  wire logic signed [COORD_BITS-1:0] c_east,
   input  wire logic signed [COORD_BITS-1:0] c_north,
   input  wire logic signed [COORD_BITS-1:0] c_up,
   output logic out_valid,
   output tls_pkg::norm_type out_data
);
   localparam int UW = COORD_BITS + 1;
   localparam int PW = 2 * UW;
   localparam int NW = PW + 1;
   localparam int MAG_W = PW;
   localparam int BL_W = $clog2(MAG_W + 1);
   localparam int EXT_W = MAG_W + tls_pkg::NORM_BITS;
   localparam int NB = tls_pkg::NORM_BITS;

   logic [6:0] vld_ff;

   logic signed [UW-1:0] u_ff [3];
   logic signed [UW-1:0] v_ff [3];
   logic signed [PW-1:0] p_ff [6];
   logic [MAG_W-1:0] mag3_ff [3];
   logic [2:0] neg3_ff;
   logic [MAG_W-1:0] mag4_ff [3];
   logic [2:0] neg4_ff;
   logic [BL_W-1:0] bl_ff;
   logic [NB-1:0] m_ff [3];
   logic [2:0] neg5_ff;
   logic [2*NB-1:0] sq_ff [3];
   logic signed [NB+16:0] pr_ff [3];
   logic [2:0] degen_ff;
   tls_pkg::norm_type out_ff;

   logic signed [NW-1:0] n_in [3];
   logic [MAG_W-1:0] mag_in [3];
   logic [MAG_W-1:0] orv;
   logic [BL_W-1:0] bl_in;
   logic [6:0] sh;
   logic [EXT_W-1:0] ext [3];
   logic [NB-1:0] m_in [3];
   logic signed [NB:0] s [3];

   // cross product differences and magnitudes
   always_comb begin
      n_in[0] = NW'(p_ff[0]) - NW'(p_ff[1]);
      n_in[1] = NW'(p_ff[2]) - NW'(p_ff[3]);
      n_in[2] = NW'(p_ff[4]) - NW'(p_ff[5]);
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = n_in[k][NW-1] ? MAG_W'(-n_in[k]) : MAG_W'(n_in[k]);
      end
   end

   // bit length of largest magnitude
   always_comb begin
      orv = mag3_ff[0] | mag3_ff[1] | mag3_ff[2];
      bl_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (orv[i]) bl_in = BL_W'(i + 1);
      end
   end

   // common shift so the largest magnitude has NORM_BITS bits
   always_comb begin
      if (int'(bl_ff) > NB) sh = 7'(int'(bl_ff) - NB);
      else sh = 7'(NB - int'(bl_ff));
      for (int k = 0; k < 3; k++) begin
         if (int'(bl_ff) > NB) ext[k] = EXT_W'(mag4_ff[k]) >> sh;
         else ext[k] = EXT_W'(mag4_ff[k]) << sh;
         m_in[k] = ext[k][NB-1:0];
      end
   end

   // signed scaled components
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s[k] = neg5_ff[k] ? -$signed({1'b0, m_ff[k]}) : $signed({1'b0, m_ff[k]});
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (en) begin
         u_ff[0] <= UW'(b_east) - UW'(a_east);
         u_ff[1] <= UW'(b_north) - UW'(a_north);
         u_ff[2] <= UW'(b_up) - UW'(a_up);
         v_ff[0] <= UW'(c_east) - UW'(a_east);
         v_ff[1] <= UW'(c_north) - UW'(a_north);
         v_ff[2] <= UW'(c_up) - UW'(a_up);

         p_ff[0] <= u_ff[1] * v_ff[2];
         p_ff[1] <= u_ff[2] * v_ff[1];
         p_ff[2] <= u_ff[2] * v_ff[0];
         p_ff[3] <= u_ff[0] * v_ff[2];
         p_ff[4] <= u_ff[0] * v_ff[1];
         p_ff[5] <= u_ff[1] * v_ff[0];

         for (int k = 0; k < 3; k++) begin
            mag3_ff[k] <= mag_in[k];
            neg3_ff[k] <= n_in[k][NW-1];
         end

         mag4_ff <= mag3_ff;
         neg4_ff <= neg3_ff;
         bl_ff <= bl_in;
         degen_ff[0] <= (bl_in == '0);

         m_ff <= m_in;
         neg5_ff <= neg4_ff;
         degen_ff[1] <= degen_ff[0];

         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= (2*NB)'(m_ff[k]) * (2*NB)'(m_ff[k]);
         end
         pr_ff[0] <= s[0] * cfg.light_east;
         pr_ff[1] <= s[1] * cfg.light_north;
         pr_ff[2] <= s[2] * cfg.light_up;
         degen_ff[2] <= degen_ff[1];

         out_ff.nn <= tls_pkg::NN_W'(sq_ff[0]) + tls_pkg::NN_W'(sq_ff[1])
                      + tls_pkg::NN_W'(sq_ff[2]);
         out_ff.dot <= tls_pkg::DOT_W'(pr_ff[0]) + tls_pkg::DOT_W'(pr_ff[1])
                       + tls_pkg::DOT_W'(pr_ff[2]);
         out_ff.degen <= degen_ff[2];
      end
   end

   assign out_valid = vld_ff[6];
   assign out_data = out_ff;
endmodule
`default_nettype wire

>>> rtl/tls_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module tls_sqrt (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  wire tls_pkg::norm_type in_data,
   output logic out_valid,
   output tls_pkg::root_type out_data
);
   localparam int RW = tls_pkg::ROOT_W;
   localparam int SW = tls_pkg::SQ_REM_W;

   logic vld_ff [RW];
   logic [SW-1:0] rem_ff [RW];
   logic [RW-1:0] root_ff [RW];
   logic signed [tls_pkg::DOT_W-1:0] dot_ff [RW];
   logic degen_ff [RW];

   for (genvar g = 0; g < RW; g++) begin : g_bit
      localparam int B = RW - 1 - g;
      logic vld_cur;
      logic [SW-1:0] rem_cur;
      logic [RW-1:0] root_cur;
      logic signed [tls_pkg::DOT_W-1:0] dot_cur;
      logic degen_cur;
      logic [SW-1:0] trial;

      // stage input select
      if (g == 0) begin : g_first
         always_comb begin
            vld_cur = in_valid;
            rem_cur = SW'(in_data.nn);
            root_cur = '0;
            dot_cur = in_data.dot;
            degen_cur = in_data.degen;
         end
      end else begin : g_next
         always_comb begin
            vld_cur = vld_ff[g-1];
            rem_cur = rem_ff[g-1];
            root_cur = root_ff[g-1];
            dot_cur = dot_ff[g-1];
            degen_cur = degen_ff[g-1];
         end
      end

      // (2r + 2^B) * 2^B against remainder
      assign trial = (SW'(root_cur) << (B + 1)) + (SW'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_cur >= trial) begin
               rem_ff[g] <= rem_cur - trial;
               root_ff[g] <= root_cur | (RW'(1) << B);
            end else begin
               rem_ff[g] <= rem_cur;
               root_ff[g] <= root_cur;
            end
            dot_ff[g] <= dot_cur;
            degen_ff[g] <= degen_cur;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_data.len = root_ff[RW-1];
   assign out_data.dot = dot_ff[RW-1];
   assign out_data.degen = degen_ff[RW-1];
endmodule
`default_nettype wire

>>> rtl/tls_div.sv
// Pipelined restoring division 2*dot/len with saturation at one.
`default_nettype none
module tls_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  wire tls_pkg::root_type in_data,
   output logic out_valid,
   output tls_pkg::inc_type out_data
);
   localparam int DW = tls_pkg::DIV_W;
   localparam int QB = tls_pkg::QUOT_BITS;

   // entry stage registers
   logic vld0_ff;
   logic [DW-1:0] rem0_ff;
   logic [tls_pkg::ROOT_W-1:0] len0_ff;
   logic sat0_ff;
   logic zero0_ff;
   logic degen0_ff;

   logic vld_ff [QB];
   logic [DW-1:0] rem_ff [QB];
   logic [tls_pkg::ROOT_W-1:0] len_ff [QB];
   logic [QB-1:0] q_ff [QB];
   logic sat_ff [QB];
   logic zero_ff [QB];
   logic degen_ff [QB];

   logic live;
   logic [DW-1:0] num;

   // positive incidence only; saturate when quotient reaches one
   assign live = !in_data.degen && (in_data.dot > 0) && (in_data.len != '0);
   assign num = {in_data.dot[DW-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff <= live ? num : '0;
         len0_ff <= in_data.len;
         sat0_ff <= num >= (DW'(in_data.len) << QB);
         zero0_ff <= !live;
         degen0_ff <= in_data.degen;
      end
   end

   for (genvar g = 0; g < QB; g++) begin : g_bit
      localparam int B = QB - 1 - g;
      logic vld_cur;
      logic [DW-1:0] rem_cur;
      logic [tls_pkg::ROOT_W-1:0] len_cur;
      logic [QB-1:0] q_cur;
      logic sat_cur;
      logic zero_cur;
      logic degen_cur;
      logic [DW-1:0] dvs;

      if (g == 0) begin : g_first
         always_comb begin
            vld_cur = vld0_ff;
            rem_cur = rem0_ff;
            len_cur = len0_ff;
            q_cur = '0;
            sat_cur = sat0_ff;
            zero_cur = zero0_ff;
            degen_cur = degen0_ff;
         end
      end else begin : g_next
         always_comb begin
            vld_cur = vld_ff[g-1];
            rem_cur = rem_ff[g-1];
            len_cur = len_ff[g-1];
            q_cur = q_ff[g-1];
            sat_cur = sat_ff[g-1];
            zero_cur = zero_ff[g-1];
            degen_cur = degen_ff[g-1];
         end
      end

      assign dvs = DW'(len_cur) << B;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_cur >= dvs) begin
               rem_ff[g] <= rem_cur - dvs;
               q_ff[g] <= q_cur | (QB'(1) << B);
            end else begin
               rem_ff[g] <= rem_cur;
               q_ff[g] <= q_cur;
            end
            len_ff[g] <= len_cur;
            sat_ff[g] <= sat_cur;
            zero_ff[g] <= zero_cur;
            degen_ff[g] <= degen_cur;
         end
      end
   end

   // final incidence select
   always_comb begin
      out_valid = vld_ff[QB-1];
      out_data.degen = degen_ff[QB-1];
      if (zero_ff[QB-1]) out_data.incidence = '0;
      else if (sat_ff[QB-1]) out_data.incidence = tls_pkg::Q16_ONE;
      else out_data.incidence = tls_pkg::Q16_W'(q_ff[QB-1]);
   end
endmodule
`default_nettype wire

>>> rtl/tls_shade.sv
// Shade blend: floor + day*(1-floor) + weight*incidence*day, three stages.
`default_nettype none
module tls_shade (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire tls_pkg::cfg_type cfg,
   input  wire logic in_valid,
   input  wire tls_pkg::inc_type in_data,
   output logic out_valid,
   output logic [tls_pkg::Q16_W-1:0] face_brightness,
   output logic [tls_pkg::Q16_W-1:0] sun_incidence,
   output logic flat_degenerate
);
   localparam int QW = tls_pkg::Q16_W;

   logic [2:0] vld_ff;
   logic [33:0] p1a_ff;
   logic [32:0] p2_ff;
   logic [QW-1:0] inc_ff [2];
   logic degen_ff [2];
   logic [33:0] p1b_ff;
   logic [49:0] p3_ff;
   logic [QW-1:0] bright_ff;
   logic [QW-1:0] incout_ff;
   logic degout_ff;

   logic [QW-1:0] f;
   logic [QW-1:0] d;
   logic [QW-1:0] omf;
   logic [50:0] total;
   logic [27:0] shade;

   // clamp floor and daylight to one
   always_comb begin
      f = (cfg.night_floor > tls_pkg::Q16_ONE) ? tls_pkg::Q16_ONE : cfg.night_floor;
      d = (cfg.day_fraction > tls_pkg::Q16_ONE) ? tls_pkg::Q16_ONE : cfg.day_fraction;
      omf = tls_pkg::Q16_ONE - f;
      total = (51'(p1b_ff) << 8) + 51'(p3_ff);
      shade = 28'(f) + 28'(total >> 24);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1a_ff <= 34'(d) * 34'(omf);
         p2_ff <= 33'(cfg.direct_weight) * 33'(in_data.incidence);
         inc_ff[0] <= in_data.incidence;
         degen_ff[0] <= in_data.degen;

         p1b_ff <= p1a_ff;
         p3_ff <= 50'(p2_ff) * 50'(d);
         inc_ff[1] <= inc_ff[0];
         degen_ff[1] <= degen_ff[0];

         bright_ff <= (shade > 28'(tls_pkg::Q16_ONE)) ? tls_pkg::Q16_ONE : QW'(shade);
         incout_ff <= inc_ff[1];
         degout_ff <= degen_ff[1];
      end
   end

   assign out_valid = vld_ff[2];
   assign face_brightness = bright_ff;
   assign sun_incidence = incout_ff;
   assign flat_degenerate = degout_ff;
endmodule
`default_nettype wire

>>> rtl/triangle_lambert_shade_top.sv
// Top level of the triangle Lambert shading pipeline with its register file.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  a/b/c vertices, east/north/up
//   rsp_      out        rsp_valid/rsp_stall  face_brightness, sun_incidence, flat_degenerate
//   csr_      in         csr_write_enable     csr_index, csr_data
//
// One triangle is taken per cycle while no result is stalled; the stages run normal, square
// root, divide, shade. The square root and the divider set the depth, one bit a stage.
// Reset is synchronous; it clears valid bits and sets the configuration registers to their reset values.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module triangle_lambert_shade_top #(
   parameter int COORD_BITS = tls_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_a_east,
   input  wire logic signed [COORD_BITS-1:0] req_a_north,
   input  wire logic signed [COORD_BITS-1:0] req_a_up,
   input  wire logic signed [COORD_BITS-1:0] req_b_east,
   input  wire logic signed [COORD_BITS-1:0] req_b_north,
   input  wire logic signed [COORD_BITS-1:0] req_b_up,
   input  wire logic signed [COORD_BITS-1:0] req_c_east,
   input  wire logic signed [COORD_BITS-1:0] req_c_north,
   input  wire logic signed [COORD_BITS-1:0] req_c_up,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [tls_pkg::Q16_W-1:0] rsp_face_brightness,
   output logic [tls_pkg::Q16_W-1:0] rsp_sun_incidence,
   output logic rsp_flat_degenerate,
   input  wire logic csr_write_enable,
   input  wire logic [tls_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tls_pkg::CSR_DATA_W-1:0] csr_data
);
   tls_pkg::cfg_type cfg_ff;
   logic en;
   logic norm_valid;
   tls_pkg::norm_type norm_data;
   logic root_valid;
   tls_pkg::root_type root_data;
   logic inc_valid;
   tls_pkg::inc_type inc_data;

   // pipeline advances unless the finished result is held
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.night_floor <= '0;
         cfg_ff.day_fraction <= '0;
         cfg_ff.direct_weight <= '0;
         cfg_ff.light_east <= tls_pkg::LIGHT_EAST_RST;
         cfg_ff.light_north <= tls_pkg::LIGHT_NORTH_RST;
         cfg_ff.light_up <= tls_pkg::LIGHT_UP_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tls_pkg::CSR_NIGHT_FLOOR: cfg_ff.night_floor <= csr_data;
            tls_pkg::CSR_DAY_FRACTION: cfg_ff.day_fraction <= csr_data;
            tls_pkg::CSR_DIRECT_WEIGHT: cfg_ff.direct_weight <= csr_data[15:0];
            tls_pkg::CSR_LIGHT_EAST: cfg_ff.light_east <= csr_data[15:0];
            tls_pkg::CSR_LIGHT_NORTH: cfg_ff.light_north <= csr_data[15:0];
            tls_pkg::CSR_LIGHT_UP: cfg_ff.light_up <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   tls_normal #(.COORD_BITS(COORD_BITS)) u_normal (
      .clock(clock), .reset(reset), .en(en), .cfg(cfg_ff),
      .in_valid(req_valid && !req_stall),
      .a_east(req_a_east), .a_north(req_a_north), .a_up(req_a_up),
      .b_east(req_b_east), .b_north(req_b_north), .b_up(req_b_up),
      .c_east(req_c_east), .c_north(req_c_north), .c_up(req_c_up),
      .out_valid(norm_valid), .out_data(norm_data)
   );

   tls_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(norm_valid), .in_data(norm_data),
      .out_valid(root_valid), .out_data(root_data)
   );

   tls_div u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(root_valid), .in_data(root_data),
      .out_valid(inc_valid), .out_data(inc_data)
   );

   tls_shade u_shade (
      .clock(clock), .reset(reset), .en(en), .cfg(cfg_ff),
      .in_valid(inc_valid), .in_data(inc_data),
      .out_valid(rsp_valid),
      .face_brightness(rsp_face_brightness),
      .sun_incidence(rsp_sun_incidence),
      .flat_degenerate(rsp_flat_degenerate)
   );
endmodule
`default_nettype wire

>>> tb/sv/triangle_lambert_shade_checker.sv
// Checker for the triangle shading block: watches the channels, predicts and compares results.
`default_nettype none
module triangle_lambert_shade_checker #(
   parameter int COORD_BITS = tls_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_a_east,
   input  wire logic signed [COORD_BITS-1:0] req_a_north,
   input  wire logic signed [COORD_BITS-1:0] req_a_up,
   input  wire logic signed [COORD_BITS-1:0] req_b_east,
   input  wire logic signed [COORD_BITS-1:0] req_b_north,
   input  wire logic signed [COORD_BITS-1:0] req_b_up,
   input  wire logic signed [COORD_BITS-1:0] req_c_east,
   input  wire logic signed [COORD_BITS-1:0] req_c_north,
   input  wire logic signed [COORD_BITS-1:0] req_c_up,
   input  wire logic rsp_valid,
   input  wire logic rsp_stall,
   input  wire logic [tls_pkg::Q16_W-1:0] rsp_face_brightness,
   input  wire logic [tls_pkg::Q16_W-1:0] rsp_sun_incidence,
   input  wire logic rsp_flat_degenerate,
   input  wire logic csr_write_enable,
   input  wire logic [tls_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tls_pkg::CSR_DATA_W-1:0] csr_data,
   output int fail_count,
   output int shades_pending,
   output int shades_checked,
   output int flat_seen,
   output int lit_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [tls_pkg::Q16_W-1:0] brightness;
      logic [tls_pkg::Q16_W-1:0] incidence;
      logic degenerate;
   } shade_type;

   shade_type expected_shades[$];

   // local copy of the register file
   logic [tls_pkg::Q16_W-1:0] floor_reg, day_reg;
   logic [15:0] weight_reg;
   logic signed [15:0] east_reg, north_reg, up_reg;

   // integer square root, one result bit per pass
   function automatic logic [63:0] int_sqrt(input logic [63:0] val);
      logic [63:0] root, bitv, rem;
      rem = val;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // flat Lambert shade of one triangle under the current registers
   function automatic shade_type predict_shade(input longint pt[9]);
      shade_type res;
      longint u[3], v[3], nrm[3], scaled[3];
      logic [63:0] mag[3], nn, len, m, f, d, inc, shade, tmp;
      int maxbits, b, k;
      longint dot;
      for (k = 0; k < 3; k++) begin
         u[k] = pt[3+k] - pt[k];
         v[k] = pt[6+k] - pt[k];
      end
      nrm[0] = u[1]*v[2] - u[2]*v[1];
      nrm[1] = u[2]*v[0] - u[0]*v[2];
      nrm[2] = u[0]*v[1] - u[1]*v[0];
      maxbits = 0;
      for (k = 0; k < 3; k++) begin
         mag[k] = nrm[k] < 0 ? 64'(-nrm[k]) : 64'(nrm[k]);
         b = 0;
         tmp = mag[k];
         while (tmp != 0) begin
            b++;
            tmp = tmp >> 1;
         end
         if (b > maxbits) maxbits = b;
      end
      inc = 0;
      res.degenerate = (maxbits == 0);
      if (maxbits != 0) begin
         nn = 0;
         for (k = 0; k < 3; k++) begin
            m = maxbits > tls_pkg::NORM_BITS ? mag[k] >> (maxbits - tls_pkg::NORM_BITS)
                                             : mag[k] << (tls_pkg::NORM_BITS - maxbits);
            nn += m * m;
            scaled[k] = nrm[k] < 0 ? -longint'(m) : longint'(m);
         end
         len = int_sqrt(nn);
         dot = scaled[0]*longint'(east_reg) + scaled[1]*longint'(north_reg)
             + scaled[2]*longint'(up_reg);
         if (dot > 0 && len != 0) begin
            inc = (64'(dot) * 2) / len;
            if (inc > 65536) inc = 65536;
         end
      end
      // values above one are taken as one
      f = floor_reg > tls_pkg::Q16_ONE ? 64'd65536 : 64'(floor_reg);
      d = day_reg > tls_pkg::Q16_ONE ? 64'd65536 : 64'(day_reg);
      shade = f + ((d * (65536 - f) * 256 + 64'(weight_reg) * inc * d) >> 24);
      if (shade > 65536) shade = 65536;
      res.brightness = shade[tls_pkg::Q16_W-1:0];
      res.incidence = inc[tls_pkg::Q16_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      shade_type exp_s, got;
      longint pts[9];
      if (reset) begin
         floor_reg <= '0;
         day_reg <= '0;
         weight_reg <= '0;
         east_reg <= tls_pkg::LIGHT_EAST_RST;
         north_reg <= tls_pkg::LIGHT_NORTH_RST;
         up_reg <= tls_pkg::LIGHT_UP_RST;
         expected_shades.delete();
         fail_count <= 0;
         shades_pending <= 0;
         shades_checked <= 0;
         flat_seen <= 0;
         lit_seen <= 0;
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_write_enable) begin
            case (csr_index)
               tls_pkg::CSR_NIGHT_FLOOR: floor_reg <= csr_data;
               tls_pkg::CSR_DAY_FRACTION: day_reg <= csr_data;
               tls_pkg::CSR_DIRECT_WEIGHT: weight_reg <= csr_data[15:0];
               tls_pkg::CSR_LIGHT_EAST: east_reg <= csr_data[15:0];
               tls_pkg::CSR_LIGHT_NORTH: north_reg <= csr_data[15:0];
               tls_pkg::CSR_LIGHT_UP: up_reg <= csr_data[15:0];
               default: ;
            endcase
         end
         // triangle transfer
         if (req_valid && !req_stall) begin
            pts[0] = longint'(req_a_east);
            pts[1] = longint'(req_a_north);
            pts[2] = longint'(req_a_up);
            pts[3] = longint'(req_b_east);
            pts[4] = longint'(req_b_north);
            pts[5] = longint'(req_b_up);
            pts[6] = longint'(req_c_east);
            pts[7] = longint'(req_c_north);
            pts[8] = longint'(req_c_up);
            expected_shades.push_back(predict_shade(pts));
         end
         // result transfer
         if (rsp_valid && !rsp_stall) begin
            got.brightness = rsp_face_brightness;
            got.incidence = rsp_sun_incidence;
            got.degenerate = rsp_flat_degenerate;
            if (expected_shades.size() == 0) begin
               $display("%0t: unexpected result bright=%0d inc=%0d flat=%0d", $realtime,
                        got.brightness, got.incidence, got.degenerate);
               fail_count <= fail_count + 1;
            end else begin
               exp_s = expected_shades.pop_front();
               if (got.brightness !== exp_s.brightness || got.incidence !== exp_s.incidence
                   || got.degenerate !== exp_s.degenerate) begin
                  $display("%0t: mismatch expected bright=%0d inc=%0d flat=%0d, got %0d %0d %0d",
                           $realtime, exp_s.brightness, exp_s.incidence, exp_s.degenerate,
                           got.brightness, got.incidence, got.degenerate);
                  fail_count <= fail_count + 1;
               end
               shades_checked <= shades_checked + 1;
               if (exp_s.degenerate) flat_seen <= flat_seen + 1;
               if (exp_s.incidence != 0) lit_seen <= lit_seen + 1;
            end
         end
         shades_pending <= expected_shades.size();
      end
   end
endmodule
`default_nettype wire

>>> tb/sv/triangle_lambert_shade_top_tb.sv
// Stimulus and verdict for the triangle shading block.
`default_nettype none
module triangle_lambert_shade_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = tls_pkg::COORD_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CB-1:0] CMAX = 24'h7FFFFF;
   localparam logic [CB-1:0] CMIN = 24'h800000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0, rsp_flat_degenerate;
   logic signed [CB-1:0] pts[9];
   logic signed [CB-1:0] req_a_east = 0, req_a_north = 0, req_a_up = 0;
   logic signed [CB-1:0] req_b_east = 0, req_b_north = 0, req_b_up = 0;
   logic signed [CB-1:0] req_c_east = 0, req_c_north = 0, req_c_up = 0;
   logic [tls_pkg::Q16_W-1:0] rsp_face_brightness, rsp_sun_incidence;
   logic csr_write_enable = 0;
   logic [tls_pkg::CSR_IDX_W-1:0] csr_index = 0;
   logic [tls_pkg::CSR_DATA_W-1:0] csr_data = 0;
   int fail_count, shades_pending, shades_checked, flat_seen, lit_seen;
   int idle_pct = 0, stall_pct = 0, cycles = 0, sent = 0;

   triangle_lambert_shade_top dut (.*);
   triangle_lambert_shade_checker chk (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, shades_pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // one triangle transfer from pts, with random idle cycles in front
   task automatic send_tri();
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_a_east <= pts[0]; req_a_north <= pts[1]; req_a_up <= pts[2];
      req_b_east <= pts[3]; req_b_north <= pts[4]; req_b_up <= pts[5];
      req_c_east <= pts[6]; req_c_north <= pts[7]; req_c_up <= pts[8];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic set_tri(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
      pts[0] = CB'(a0); pts[1] = CB'(a1); pts[2] = CB'(a2);
      pts[3] = CB'(b0); pts[4] = CB'(b1); pts[5] = CB'(b2);
      pts[6] = CB'(c0); pts[7] = CB'(c1); pts[8] = CB'(c2);
      send_tri();
   endtask

   task automatic csr_write(input logic [tls_pkg::CSR_IDX_W-1:0] idx, input int val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_data <= tls_pkg::CSR_DATA_W'(val);
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   // block is idle only once every result is back
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (shades_pending != 0) @(posedge clock);
   endtask

   task automatic load_regs(input int fl, dy, wt, le, ln, lu);
      csr_write(tls_pkg::CSR_NIGHT_FLOOR, fl);
      csr_write(tls_pkg::CSR_DAY_FRACTION, dy);
      csr_write(tls_pkg::CSR_DIRECT_WEIGHT, wt);
      csr_write(tls_pkg::CSR_LIGHT_EAST, le);
      csr_write(tls_pkg::CSR_LIGHT_NORTH, ln);
      csr_write(tls_pkg::CSR_LIGHT_UP, lu);
   endtask

   // random triangle: mostly terrain-like patches, some full range, some flat
   task automatic random_tri();
      int kind, base, k, j;
      kind = $urandom_range(99);
      if (kind < 15) begin
         for (k = 0; k < 9; k++) pts[k] = CB'($urandom);
      end else begin
         for (k = 0; k < 3; k++) begin
            base = $urandom;
            for (j = 0; j < 3; j++) begin
               pts[3*j+k] = CB'(base + int'($urandom_range(4000)) - 2000);
            end
         end
         // collinear or coincident vertices give a flat normal
         if (kind >= 88) begin
            for (k = 0; k < 3; k++) pts[6+k] = CB'(pts[k] + 2 * (pts[3+k] - pts[k]));
         end else if (kind >= 84) begin
            for (k = 0; k < 3; k++) pts[3+k] = pts[k];
         end
      end
      send_tri();
   endtask

   initial begin
      int ph, n;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed triangles under reset register values, then full day
      for (ph = 0; ph < 2; ph++) begin
         set_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
         set_tri(5, 6, 7, 5, 6, 7, 5, 6, 7);
         set_tri(0, 0, 0, 1, 1, 1, 2, 2, 2);
         set_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
         set_tri(0, 0, 0, 0, 1, 0, 1, 0, 0);
         set_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
         set_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX);
         set_tri(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN);
         set_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN);
         set_tri(-1, -1, -1, CMAX, 0, 0, 0, CMAX, 0);
         drain();
         if (ph == 0) load_regs(65536, 65536, 65535, 14746, 8192, 28180);
      end

      // random phases: each idling mode with a different register setting
      for (ph = 0; ph < 8; ph++) begin
         idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 86 : 0;
         stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 86 : 0;
         if (ph % 4 == 3) begin
            idle_pct = 29;
            stall_pct = 29;
         end
         case (ph)
            0: load_regs(0, 0, 0, -32768, -32768, -32768);
            1: load_regs(131071, 131071, 65535, 32767, 32767, 32767);
            2: load_regs(16384, 40000, 256, 0, 0, 32767);
            3: load_regs(65537, 0, 1, -32768, 0, 0);
            4: load_regs(0, 65536, 65535, 0, 32767, 0);
            default:
               load_regs($urandom_range(70000), $urandom_range(70000), $urandom_range(65535),
                         $urandom, $urandom, $urandom);
         endcase
         // writes beyond the register list must be ignored
         csr_write(3'd6, $urandom);
         csr_write(3'd7, $urandom);
         for (n = 0; n < 100; n++) random_tri();
         drain();
      end

      repeat (80) @(posedge clock);
      $display("%0d triangles sent, %0d results checked (%0d flat, %0d lit)",
               sent, shades_checked, flat_seen, lit_seen);
      $display("register settings swept over 10 phases, all idle and stall modes");
      if (fail_count == 0 && shades_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
